FILE: design/rsms_pkg.sv
// Shared types and constants for the range subarray minimum sum block.
`timescale 1ns / 1ps

package rsms_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int AW           = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = AW + 1;
  localparam int VAL_W        = 32;
  localparam int EMS_W        = VAL_W + CNT_W;
  localparam int ANS_W        = 61;
  localparam int CFG_W        = 11;
  localparam int FIELD_IDX_W  = 10;

  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(1024);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                          op;
    logic [FIELD_IDX_W-1:0]        load_index;
    logic signed [VAL_W-1:0]       load_value;
    logic [FIELD_IDX_W-1:0]        range_left;
    logic [FIELD_IDX_W-1:0]        range_right;
  } in_item_t;

  typedef struct packed {
    logic signed [ANS_W-1:0] answer;
    logic                    range_error;
  } out_item_t;

  // One stack entry: element value, its position, and one past the
  // position of the entry beneath it.
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [AW-1:0]           idx;
    logic [CNT_W-1:0]        bp1;
  } stack_entry_t;

  localparam int STACK_W = $bits(stack_entry_t);

endpackage

FILE: design/rsms_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rsms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/range_subarray_min_sum.sv
// Top level: sum of subrange minimums over a query range, one shared multiplier.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in_     | input     | in_valid / in_stall   | in_data  (rsms_pkg::in_item_t)
//  out_    | output    | out_valid / out_stall | out_data (rsms_pkg::out_item_t)
//  cfg_    | input     | cfg_we                | cfg_data (element_count)
//
//  A load is written to the element RAM when taken. A valid query runs fetch,
//  check, multiply, accumulate and total per position, plus check, multiply and
//  accumulate per stack pop; an invalid query goes straight to S_DONE. The pace
//  is set by the single multiplier and the element RAM read port: each push and
//  each pop makes one pass through multiply and accumulate. Reset (rst_n low,
//  synchronous) clears the sequencer and output valid and returns the count
//  register to 1024; the memories need no clearing. A stalled result holds in
//  the output register while the next item may already be taken and worked.

module range_subarray_min_sum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  rsms_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rsms_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [rsms_pkg::CFG_W-1:0] cfg_data
);

  import rsms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_MUL,
    S_ACC,
    S_TOTAL,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [CFG_W-1:0]        count_r;
  logic [AW-1:0]           pos_r;
  logic [AW-1:0]           left_r;
  logic [AW-1:0]           right_r;
  logic [CNT_W-1:0]        depth_r;
  stack_entry_t            top_r;
  logic signed [VAL_W-1:0] mul_a_r;
  logic [CNT_W-1:0]        mul_b_r;
  logic                    pop_r;
  logic signed [EMS_W-1:0] prod_r;
  logic signed [EMS_W-1:0] ems_r;
  logic signed [ANS_W-1:0] total_r;
  logic                    err_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic                    in_xfer;
  logic                    out_free;
  logic                    query_bad;
  logic                    load_ok;
  logic signed [VAL_W-1:0] cur_val;
  logic                    do_pop;
  logic [CNT_W-1:0]        push_bp1;
  logic [CNT_W-1:0]        push_width;
  logic [CNT_W-1:0]        pop_width;
  logic signed [VAL_W+CNT_W:0] prod_full;

  logic [VAL_W-1:0]        elem_rdata;
  logic                    elem_we;
  stack_entry_t            stk_wdata;
  logic [STACK_W-1:0]      stk_rdata;
  logic                    stk_we;

  // Accept only while idle; a waiting result does not block the input.
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Range check against the count saturated to the store depth.
  always_comb begin
    int eff;
    eff = (32'(count_r) > MAX_ELEMENTS) ? MAX_ELEMENTS : 32'(count_r);
    query_bad = (in_data.range_left > in_data.range_right) ||
                (32'(in_data.range_right) >= eff);
    load_ok   = 32'(in_data.load_index) < MAX_ELEMENTS;
  end

  assign elem_we = in_xfer && (in_data.op == OP_LOAD) && load_ok;

  rsms_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (AW'(in_data.load_index)),
    .wdata (in_data.load_value),
    .raddr (pos_r),
    .rdata (elem_rdata)
  );

  // The current element stays on the read port while pos_r holds.
  assign cur_val = $signed(elem_rdata);

  assign do_pop     = (depth_r != '0) && (top_r.val >= cur_val);
  assign push_bp1   = (depth_r != '0) ? (CNT_W'(top_r.idx) + CNT_W'(1)) : CNT_W'(left_r);
  assign push_width = CNT_W'(pos_r) + CNT_W'(1) - push_bp1;
  assign pop_width  = CNT_W'(top_r.idx) + CNT_W'(1) - top_r.bp1;

  // The cached top goes to RAM below the new top on a push; a pop reloads
  // the top from the entry beneath it, read during the check cycle.
  assign stk_we    = (state_r == S_CHECK) && !do_pop && (depth_r != '0);
  assign stk_wdata = top_r;

  rsms_ram #(
    .WIDTH (STACK_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (AW'(depth_r - CNT_W'(1))),
    .wdata (stk_wdata),
    .raddr (AW'(depth_r - CNT_W'(2))),
    .rdata (stk_rdata)
  );

  // Shared multiplier: signed value times unsigned span.
  assign prod_full = (VAL_W+CNT_W+1)'(mul_a_r) * (VAL_W+CNT_W+1)'($signed({1'b0, mul_b_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      pop_r       <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_data;
      end

      // Drop the result once the transfer completes, unless a new one lands.
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer && (in_data.op == OP_QUERY)) begin
            left_r  <= AW'(in_data.range_left);
            right_r <= AW'(in_data.range_right);
            pos_r   <= AW'(in_data.range_left);
            depth_r <= '0;
            ems_r   <= '0;
            total_r <= '0;
            err_r   <= query_bad;
            state_r <= query_bad ? S_DONE : S_FETCH;
          end
        end

        S_FETCH: begin
          state_r <= S_CHECK;
        end

        S_CHECK: begin
          pop_r <= do_pop;
          if (do_pop) begin
            mul_a_r <= top_r.val;
            mul_b_r <= pop_width;
          end else begin
            mul_a_r     <= cur_val;
            mul_b_r     <= push_width;
            top_r.val   <= cur_val;
            top_r.idx   <= pos_r;
            top_r.bp1   <= push_bp1;
            depth_r     <= depth_r + CNT_W'(1);
          end
          state_r <= S_MUL;
        end

        S_MUL: begin
          prod_r <= prod_full[EMS_W-1:0];
          if (pop_r) begin
            top_r   <= stk_rdata;
            depth_r <= depth_r - CNT_W'(1);
          end
          state_r <= S_ACC;
        end

        S_ACC: begin
          if (pop_r) begin
            ems_r   <= ems_r - prod_r;
            state_r <= S_CHECK;
          end else begin
            ems_r   <= ems_r + prod_r;
            state_r <= S_TOTAL;
          end
        end

        S_TOTAL: begin
          total_r <= total_r + ANS_W'(ems_r);
          if (pos_r == right_r) begin
            state_r <= S_DONE;
          end else begin
            pos_r   <= pos_r + AW'(1);
            state_r <= S_FETCH;
          end
        end

        S_DONE: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.answer      <= err_r ? '0 : total_r;
            out_data_r.range_error <= err_r;
            state_r                <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
